/* sv/hrca_pkg.sv */
`timescale 1ns / 1ps

package hrca_pkg;

  localparam int SUM_W     = 48;
  localparam int WEIGHT_W  = 32;
  localparam int VC_W      = 21;
  localparam int WS_W      = 7;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // broadcast to every cell of the row
  typedef struct packed {
    logic                clear;
    logic                shift;
    logic                add;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    hi;
    logic [WEIGHT_W-1:0] weight;
  } cell_ctl_t;

endpackage

/* sv/hrca_cell.sv */
`timescale 1ns / 1ps

module hrca_cell import hrca_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [SUM_W-1:0] shift_in,
  output logic [SUM_W-1:0] sum
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic           in_range;
  logic [SUM_W:0] wide;
  logic [SUM_W-1:0] sum_next;

  assign in_range = (MY_IDX >= ctl.lo) && (MY_IDX < ctl.hi);
  assign wide     = {1'b0, sum} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, ctl.weight};

  always_comb begin
    priority if (ctl.clear) begin
      sum_next = '0;
    end else if (ctl.shift) begin
      sum_next = shift_in;
    end else if (ctl.add && in_range) begin
      sum_next = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end

endmodule

/* sv/hyperedge_range_cut_accumulator.sv */
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// edge in   in         start & !busy           first_vertex end_vertex edge_weight final_edge
// result    out        result_strobe           cut_value cut_slot last_cut
// config    in         cfg_valid & cfg_ready   cfg_index cfg_data
//
// an edge: the accept cycle works out the slot range, the next cycle adds the weight
// in parallel in every cell of the row whose slot lies in that range.
// a final edge then emits the kept window: slot sums shift one cell a cycle out of cell 0.
// reset (rst, synchronous) zeroes all slot sums; vertex_count and window_size reset to 64.
// results cannot be stalled; cfg_ready is always high.

module hyperedge_range_cut_accumulator import hrca_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int VERTEX_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VERTEX_BITS-1:0] first_vertex,
  input  logic [VERTEX_BITS-1:0] end_vertex,
  input  logic [WEIGHT_W-1:0]    edge_weight,
  input  logic                   final_edge,
  output logic                   result_strobe,
  output logic [SUM_W-1:0]       cut_value,
  output logic [SLOT_W-1:0]      cut_slot,
  output logic                   last_cut,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [VC_W-1:0]        cfg_data
);

  localparam int CW = ((VERTEX_BITS > VC_W) ? VERTEX_BITS : VC_W) + 1;
  localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state, state_next;
  logic [VC_W-1:0]     vertex_count;
  logic [WS_W-1:0]     window_size;
  logic [CNT_W-1:0]    lo_q, hi_q, w_q, cnt, cnt_next;
  logic [WEIGHT_W-1:0] weight_q;
  logic                final_q;

  logic [CNT_W-1:0] w_win, w_keep, lo_c, hi_c;
  logic [CW-1:0]    vc_x, base, fv, ev, lo_v, hi_v, dlo, dhi;
  logic             accept, last_emit;
  cell_ctl_t        ctl;
  logic [SUM_W-1:0] sums [MAX_WINDOW];

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_W'(64);
      window_size  <= WS_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_VERTEX_COUNT) begin
        vertex_count <= cfg_data;
      end else if (cfg_index == REG_WINDOW_SIZE) begin
        window_size <= cfg_data[WS_W-1:0];
      end
    end
  end

  // kept window and slot range of the incoming edge
  always_comb begin
    w_win  = (window_size > MAXW) ? MAXW : window_size;
    w_keep = (CW'(w_win) > CW'(vertex_count)) ? vertex_count[CNT_W-1:0] : w_win;
    vc_x   = CW'(vertex_count);
    base   = vc_x - CW'(w_keep);
    fv     = CW'(first_vertex);
    ev     = CW'(end_vertex);
    lo_v   = (fv > base) ? fv : base;
    hi_v   = (ev < vc_x) ? ev : vc_x;
    dlo    = lo_v - base;
    dhi    = hi_v - base;
    if (hi_v > lo_v) begin
      lo_c = (dlo > CW'(MAX_WINDOW)) ? MAXW : dlo[CNT_W-1:0];
      hi_c = dhi[CNT_W-1:0];
    end else begin
      lo_c = '0;
      hi_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_q     <= lo_c;
      hi_q     <= hi_c;
      w_q      <= w_keep;
      weight_q <= edge_weight;
      final_q  <= final_edge;
    end
  end

  assign last_emit = (cnt + CNT_W'(1) == w_q);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ADD;
      end
      ST_ADD: begin
        cnt_next = '0;
        if (final_q && (w_q != '0)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cnt_next = cnt + CNT_W'(1);
        if (last_emit) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    ctl.add    = (state == ST_ADD);
    ctl.shift  = (state == ST_EMIT);
    // an empty window still clears on the final edge
    ctl.clear  = ((state == ST_ADD) && final_q && (w_q == '0)) ||
                 ((state == ST_EMIT) && last_emit);
    ctl.lo     = lo_q;
    ctl.hi     = hi_q;
    ctl.weight = weight_q;
  end

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [SUM_W-1:0] nb;
    if (k == MAX_WINDOW - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = sums[k + 1];
    end
    hrca_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift_in (nb),
      .sum      (sums[k])
    );
  end

  assign result_strobe = (state == ST_EMIT);
  assign cut_value     = sums[0];
  assign cut_slot      = cnt[SLOT_W-1:0];
  assign last_cut      = result_strobe && last_emit;

`ifndef NO_ASSERTIONS
  a_emit_in_window: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (cnt < w_q) && (w_q <= MAXW))
    else $error("slot counter out of window");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (rst)
    last_cut |=> (state == ST_IDLE) && (sums[0] == '0))
    else $error("emission did not end and clear");

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |=> (state == ST_IDLE) || (state == ST_EMIT))
    else $error("add phase did not finish");

  a_range_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> (hi_q <= w_q))
    else $error("slot range past window");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hrca_pkg::*;

  localparam int VB         = 20;
  localparam int MAX_WIN    = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_EDGES = 260;

  localparam logic [VB-1:0] VMAX = '1;
  // indexes the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [VB-1:0]       lo_v;
    logic [VB-1:0]       hi_v;
    logic [WEIGHT_W-1:0] wt;
    logic                fin;
  } edge_t;

  typedef struct packed {
    logic [SUM_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } cut_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [VB-1:0] first_vertex = '0;
  logic [VB-1:0] end_vertex = '0;
  logic [WEIGHT_W-1:0] edge_weight = '0;
  logic final_edge = 1'b0;
  logic result_strobe;
  logic [SUM_W-1:0] cut_value;
  logic [SLOT_W-1:0] cut_slot;
  logic last_cut;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VC_W-1:0] cfg_data = '0;

  hyperedge_range_cut_accumulator #(
    .MAX_WINDOW (MAX_WIN),
    .VERTEX_BITS(VB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_vertex (first_vertex),
    .end_vertex   (end_vertex),
    .edge_weight  (edge_weight),
    .final_edge   (final_edge),
    .result_strobe(result_strobe),
    .cut_value    (cut_value),
    .cut_slot     (cut_slot),
    .last_cut     (last_cut),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // mirror of the block's state
  logic [SUM_W-1:0] slot_sum [MAX_WIN];
  logic [VC_W-1:0]  vertex_total = 21'd64;
  logic [WS_W-1:0]  window_req = 7'd64;

  edge_t edge_backlog[$];
  cut_t  expected_cuts[$];

  int edges_queued = 0;
  int edges_taken = 0;
  int random_edges = 0;
  int emissions = 0;
  int words_checked = 0;
  int writes_done = 0;
  int fault_count = 0;
  int gap_left = 0;
  bit no_gaps = 1'b0;

  initial begin
    for (int k = 0; k < MAX_WIN; k++) slot_sum[k] = '0;
  end

  task automatic flag(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  function automatic longint unsigned window_now();
    longint unsigned w;
    w = window_req;
    if (w > MAX_WIN) w = MAX_WIN;
    if (w > vertex_total) w = vertex_total;
    return w;
  endfunction

  function automatic logic [VB-1:0] vclip(input longint unsigned v);
    return (v > VMAX) ? VMAX : v[VB-1:0];
  endfunction

  // adds one edge to the mirrored slots; a final edge emits the window then clears
  task automatic add_edge(input logic [VB-1:0] lo_v, input logic [VB-1:0] hi_v,
                          input logic [WEIGHT_W-1:0] wt, input logic fin);
    longint unsigned win, base, t, sum;
    int s;
    cut_t c;
    win = window_now();
    base = vertex_total - win;
    for (s = 0; s < win; s++) begin
      t = base + s;
      if (t >= lo_v && t < hi_v) begin
        sum = slot_sum[s] + wt;
        slot_sum[s] = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
      end
    end
    if (fin) begin
      emissions++;
      for (s = 0; s < win; s++) begin
        c.value = slot_sum[s];
        c.slot  = s[SLOT_W-1:0];
        c.last  = (s + 1 == win);
        expected_cuts.push_back(c);
      end
      for (s = 0; s < MAX_WIN; s++) slot_sum[s] = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // edges mostly land on the kept window, the rest are stray or reversed
  function automatic edge_t make_edge(input logic fin);
    edge_t e;
    longint unsigned win, base, a;
    int r;
    win = window_now();
    base = vertex_total - win;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      a = base + $urandom_range(0, win);
      e.lo_v = vclip(a);
      e.hi_v = vclip(a + $urandom_range(1, win + 2));
    end else if (r < 75) begin
      e.lo_v = vclip($urandom_range(0, base));
      e.hi_v = vclip(base + $urandom_range(0, win + 2));
    end else if (r < 85) begin
      a = base + $urandom_range(0, win);
      e.hi_v = vclip(a);
      e.lo_v = vclip(a + $urandom_range(0, 4));
    end else begin
      e.lo_v = VB'($urandom);
      e.hi_v = VB'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 10) e.wt = '1;
    else if (r < 15) e.wt = '0;
    else if (r < 40) e.wt = $urandom_range(1, 65535);
    else e.wt = $urandom;
    e.fin = fin;
    return e;
  endfunction

  task automatic queue_edge(input logic [VB-1:0] lo_v, input logic [VB-1:0] hi_v,
                            input logic [WEIGHT_W-1:0] wt, input logic fin);
    edge_t e;
    e.lo_v = lo_v;
    e.hi_v = hi_v;
    e.wt = wt;
    e.fin = fin;
    edge_backlog.push_back(e);
    edges_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VC_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VERTEX_COUNT: vertex_total = val;
      REG_WINDOW_SIZE:  window_req = val[WS_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // block idle: every edge taken, every cut word seen, and busy low
  task automatic settle();
    while (edges_taken != edges_queued || expected_cuts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // edge driver
  always @(posedge clk) begin : drive
    logic go;
    edge_t nxt;
    go = start;
    if (rst) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        add_edge(first_vertex, end_vertex, edge_weight, final_edge);
        edges_taken++;
        go = 1'b0;
        gap_left = pick_gap();
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (edge_backlog.size() > 0) begin
          nxt = edge_backlog.pop_front();
          first_vertex <= nxt.lo_v;
          end_vertex <= nxt.hi_v;
          edge_weight <= nxt.wt;
          final_edge <= nxt.fin;
          go = 1'b1;
        end
      end
    end
    start <= go;
  end

  // cut word monitor
  always @(posedge clk) begin : monitor
    cut_t want;
    if (!rst && result_strobe) begin
      words_checked++;
      if (expected_cuts.size() == 0) begin
        flag($sformatf("unexpected cut word: slot %0d value %h last %0d",
                       cut_slot, cut_value, last_cut));
      end else begin
        want = expected_cuts.pop_front();
        if (cut_value !== want.value || cut_slot !== want.slot || last_cut !== want.last)
          flag($sformatf("cut mismatch: expected slot %0d value %h last %0d, got slot %0d value %h last %0d",
                         want.slot, want.value, want.last, cut_slot, cut_value, last_cut));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int r, batch;
    bit close_run;
    edge_t e;
    logic [VC_W-1:0] vc_pick;
    logic [WS_W-1:0] ws_pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window: 64 slots over 64 vertices
    queue_edge('0, 20'd64, '1, 1'b0);
    queue_edge('0, '0, 32'd5, 1'b0);
    queue_edge(20'd10, 20'd3, 32'd7, 1'b0);
    queue_edge(20'd63, VMAX, 32'd1, 1'b0);
    queue_edge(VMAX, VMAX, '1, 1'b0);
    queue_edge(20'd5, 20'd6, 32'h0001_0000, 1'b0);
    queue_edge('0, 20'd64, '0, 1'b0);
    queue_edge(20'd20, 20'd40, 32'h1234_5678, 1'b1);
    settle();
    // no vertices: nothing emitted but the slots still clear
    write_reg(REG_VERTEX_COUNT, '0);
    queue_edge('0, 20'd64, 32'hdead_beef, 1'b0);
    queue_edge('0, 20'd1, 32'd1, 1'b1);
    settle();
    write_reg(REG_VERTEX_COUNT, 21'd64);
    queue_edge('0, 20'd64, 32'd3, 1'b1);
    settle();
    // window wider than the graph
    write_reg(REG_VERTEX_COUNT, 21'd3);
    queue_edge('0, 20'd5, 32'h0000_ffff, 1'b1);
    settle();
    // oversized window request
    write_reg(REG_WINDOW_SIZE, 21'd100);
    write_reg(REG_VERTEX_COUNT, 21'd1000);
    queue_edge(20'd900, 20'd950, 32'd9, 1'b0);
    queue_edge(20'd999, VMAX, 32'd2, 1'b1);
    settle();
    write_reg(REG_WINDOW_SIZE, '0);
    queue_edge('0, VMAX, 32'd1, 1'b1);
    settle();
    // sums carry across a window change
    write_reg(REG_WINDOW_SIZE, 21'd8);
    write_reg(REG_VERTEX_COUNT, 21'd16);
    queue_edge('0, 20'd16, 32'h100, 1'b0);
    settle();
    write_reg(REG_WINDOW_SIZE, 21'd4);
    queue_edge(20'd13, 20'd14, 32'd1, 1'b1);
    settle();
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    write_reg(REG_VERTEX_COUNT, '1);
    write_reg(REG_WINDOW_SIZE, 21'h7f);
    queue_edge(VMAX - 20'd3, VMAX, '1, 1'b1);
    settle();
    write_reg(REG_VERTEX_COUNT, 21'h10_0000);
    write_reg(REG_WINDOW_SIZE, 21'd64);
    queue_edge('0, VMAX, 32'haaaa_5555, 1'b0);
    queue_edge(VMAX - 20'd1, VMAX, 32'h5555_aaaa, 1'b1);
    settle();

    while (random_edges < RANDOM_EDGES) begin
      r = $urandom_range(0, 99);
      if (r < 25) vc_pick = VC_W'($urandom_range(1, 80));
      else if (r < 45) vc_pick = 21'd64;
      else if (r < 70) vc_pick = VC_W'($urandom_range(81, 1048576));
      else if (r < 78) vc_pick = 21'h10_0000;
      else if (r < 84) vc_pick = VC_W'($urandom_range(1048577, 2097151));
      else if (r < 88) vc_pick = '0;
      else if (r < 92) vc_pick = 21'd1;
      else vc_pick = VC_W'($urandom_range(2, 200));
      r = $urandom_range(0, 99);
      if (r < 40) ws_pick = 7'd64;
      else if (r < 75) ws_pick = WS_W'($urandom_range(1, 63));
      else if (r < 85) ws_pick = WS_W'($urandom_range(65, 127));
      else if (r < 90) ws_pick = '0;
      else ws_pick = 7'd1;
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_VERTEX_COUNT, vc_pick);
          write_reg(REG_WINDOW_SIZE, VC_W'(ws_pick));
        end
        1: write_reg(REG_VERTEX_COUNT, vc_pick);
        2: write_reg(REG_WINDOW_SIZE, VC_W'(ws_pick));
        default: ;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(1, 30);
      close_run = ($urandom_range(0, 99) < 85);
      for (int i = 0; i < batch; i++) begin
        e = make_edge(close_run && i == batch - 1);
        queue_edge(e.lo_v, e.hi_v, e.wt, e.fin);
      end
      random_edges += batch;
      settle();
    end

    if (expected_cuts.size() != 0)
      flag($sformatf("%0d cut words never arrived", expected_cuts.size()));
    $display("covered %0d edges (%0d random) and %0d register writes",
             edges_taken, random_edges, writes_done);
    $display("checked %0d cut words over %0d emissions, %0d faults",
             words_checked, emissions, fault_count);
    if (fault_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
